/* rtl/adtc_pkg.sv */
// Shared types and constants for the address dedup throttle cache.
package adtc_pkg;

   // Field widths fixed by the interface
   localparam int ADDR_W     = 48;
   localparam int MS_W       = 32;
   localparam int SIG_W      = 8;
   localparam int SLOT_OUT_W = 5;
   localparam int COUNT_W    = 32;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_WINDOW = 1'b0;   // register index bit paddr[2]
   localparam logic [MS_W-1:0] WINDOW_RESET = 32'd5000;

   // Search word handed from cell to cell
   typedef struct packed {
      logic            valid;
      logic            hit;
      logic            have_free;
      logic            have_oldest;
      logic [MS_W-1:0] ref_ms;       // matched entry time on hit, else oldest time
   } probe_type;

   // Broadcast entry write (slot select travels beside it)
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [MS_W-1:0]   stamp;
   } write_type;

endpackage

/* rtl/adtc_cell.sv */
// One table entry plus one stage of the search chain.
module adtc_cell #(
   parameter int IDX_W = 5,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [adtc_pkg::ADDR_W-1:0]    search_addr,
   input  adtc_pkg::probe_type            probe_in,
   input  logic [IDX_W-1:0]               pick_in,
   input  logic [IDX_W-1:0]               free_in,
   input  adtc_pkg::write_type            wr,
   input  logic [IDX_W-1:0]               wr_slot,
   output adtc_pkg::probe_type            probe_out,
   output logic [IDX_W-1:0]               pick_out,
   output logic [IDX_W-1:0]               free_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic                           valid_ff;
   logic [adtc_pkg::ADDR_W-1:0]    addr_ff;
   logic [adtc_pkg::MS_W-1:0]      stamp_ff;
   adtc_pkg::probe_type            probe_ff, probe_in_w;
   logic [IDX_W-1:0]               pick_ff, pick_in_w;
   logic [IDX_W-1:0]               free_ff, free_in_w;

   // Fold this entry into the passing search word
   always_comb begin
      probe_in_w = probe_in;
      pick_in_w  = pick_in;
      free_in_w  = free_in;
      if (probe_in.valid && !probe_in.hit) begin
         priority if (!valid_ff) begin
            probe_in_w.have_free = 1'b1;
            free_in_w            = MY_IDX;
         end else if (addr_ff == search_addr) begin
            probe_in_w.hit    = 1'b1;
            probe_in_w.ref_ms = stamp_ff;
            pick_in_w         = MY_IDX;
         end else if (!probe_in.have_oldest || stamp_ff < probe_in.ref_ms) begin
            probe_in_w.have_oldest = 1'b1;
            probe_in_w.ref_ms      = stamp_ff;
            pick_in_w              = MY_IDX;
         end
      end
   end

   // Search stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_w;
      end
      pick_ff <= pick_in_w;
      free_ff <= free_in_w;
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && wr_slot == MY_IDX) begin
         valid_ff <= 1'b1;
      end
      if (wr.en && wr_slot == MY_IDX) begin
         addr_ff  <= wr.addr;
         stamp_ff <= wr.stamp;
      end
   end

   assign probe_out = probe_ff;
   assign pick_out  = pick_ff;
   assign free_out  = free_ff;

endmodule

/* rtl/address_dedup_throttle_cache_top.sv */
// Top level: duplicate address filter with per-address report throttling.
//
// Input channel req_*: one word per sighting (address, time in ms, dBm).
// Result channel rsp_*: exactly one word per sighting, in order.
// Config port csr_*: APB-style, one register (throttle window, byte addr 0).
// Each sighting is searched by a word that walks a row of TABLE_ENTRIES
// cells, one cell per cycle. One sighting is in flight at a time: a new
// sighting is not accepted until the previous search has committed its
// result, so the sustained rate is set by the length of the cell chain.
// The finished result sits in an output register; the next sighting is
// accepted while it waits. If the receiver stalls, a finished search is
// held at the chain end and the table is not updated until the output
// register frees up.
// Reset clears all entry valid bits, the new-address counter and sets the
// throttle window to 5000 ms; the block is ready the cycle after reset.
module address_dedup_throttle_cache_top #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // sighting input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [adtc_pkg::ADDR_W-1:0]         req_device_address,
   input  logic [adtc_pkg::MS_W-1:0]           req_time_ms,
   input  logic signed [adtc_pkg::SIG_W-1:0]   req_signal_dbm,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_report_ok,
   output logic                                rsp_is_new,
   output logic [adtc_pkg::SLOT_OUT_W-1:0]     rsp_slot_used,
   output logic [adtc_pkg::ADDR_W-1:0]         rsp_address_out,
   output logic signed [adtc_pkg::SIG_W-1:0]   rsp_signal_out,
   output logic [adtc_pkg::COUNT_W-1:0]        rsp_new_count,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [adtc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [adtc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [adtc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // Configuration register
   logic [adtc_pkg::MS_W-1:0] window_ff;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= adtc_pkg::WINDOW_RESET;
      end else if (csr_write && csr_paddr[2] == adtc_pkg::CSR_IDX_WINDOW) begin
         window_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == adtc_pkg::CSR_IDX_WINDOW) ? window_ff : '0;

   // Held sighting and control flags
   logic                               busy_ff, busy_in;
   logic                               start_ff;
   logic [adtc_pkg::ADDR_W-1:0]        addr_ff;
   logic [adtc_pkg::MS_W-1:0]          now_ff;
   logic signed [adtc_pkg::SIG_W-1:0]  sig_ff;
   logic                               req_take;

   assign req_ready = !busy_ff && !reset;
   assign req_take  = req_valid && req_ready;

   // Search chain
   adtc_pkg::probe_type  probe_chain [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]     pick_chain  [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]     free_chain  [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES:0] chain_valids;
   adtc_pkg::write_type  wr;
   logic [IDX_W-1:0]     wr_slot;

   always_comb begin
      probe_chain[0]       = '0;
      probe_chain[0].valid = start_ff;
   end
   assign pick_chain[0] = '0;
   assign free_chain[0] = '0;
   assign chain_valids[0] = probe_chain[0].valid;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      adtc_cell #(
         .IDX_W (IDX_W),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .search_addr (addr_ff),
         .probe_in    (probe_chain[g]),
         .pick_in     (pick_chain[g]),
         .free_in     (free_chain[g]),
         .wr          (wr),
         .wr_slot     (wr_slot),
         .probe_out   (probe_chain[g+1]),
         .pick_out    (pick_chain[g+1]),
         .free_out    (free_chain[g+1])
      );
      assign chain_valids[g+1] = probe_chain[g+1].valid;
   end

   // Finished search held until the output register can take it
   adtc_pkg::probe_type       done_ff;
   logic                      done_valid_ff, done_valid_in;
   logic [IDX_W-1:0]          done_pick_ff, done_free_ff;
   logic                      commit;
   logic                      report;
   logic [IDX_W-1:0]          slot;
   logic [adtc_pkg::MS_W-1:0] elapsed;
   logic [adtc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                      rsp_valid_ff;

   assign commit  = done_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign elapsed = now_ff - done_ff.ref_ms;
   assign report  = !done_ff.hit || (elapsed >= window_ff);

   // Hit slot, else highest free slot, else oldest entry
   always_comb begin
      priority if (done_ff.hit)       slot = done_pick_ff;
      else if (done_ff.have_free)     slot = done_free_ff;
      else                            slot = done_pick_ff;
   end

   always_comb begin
      wr.en    = commit && report;
      wr.addr  = addr_ff;
      wr.stamp = now_ff;
      wr_slot  = slot;
   end

   assign count_in = (commit && !done_ff.hit) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      done_valid_in = done_valid_ff;
      busy_in       = busy_ff;
      if (probe_chain[TABLE_ENTRIES].valid) done_valid_in = 1'b1;
      else if (commit)                      done_valid_in = 1'b0;
      if (req_take)    busy_in = 1'b1;
      else if (commit) busy_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         done_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         start_ff      <= req_take;
         done_valid_ff <= done_valid_in;
         count_ff      <= count_in;
         if (commit)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff <= req_device_address;
         now_ff  <= req_time_ms;
         sig_ff  <= req_signal_dbm;
      end
      if (probe_chain[TABLE_ENTRIES].valid) begin
         done_ff      <= probe_chain[TABLE_ENTRIES];
         done_pick_ff <= pick_chain[TABLE_ENTRIES];
         done_free_ff <= free_chain[TABLE_ENTRIES];
      end
      if (commit) begin
         rsp_report_ok   <= report;
         rsp_is_new      <= !done_ff.hit;
         rsp_slot_used   <= adtc_pkg::SLOT_OUT_W'(slot);
         rsp_address_out <= addr_ff;
         rsp_signal_out  <= sig_ff;
         rsp_new_count   <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_one_search: assert property (@(posedge clock) disable iff (reset)
      $countones({chain_valids, done_valid_ff}) <= 1)
      else $error("more than one search in flight");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (chain_valids == '0 && !done_valid_ff))
      else $error("search word present while idle");

   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("commit did not load the output register");

   a_new_reports: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_new) |-> rsp_report_ok)
      else $error("new address not reported");

endmodule
